// ===== sv/spbv_pkg.sv =====
// package for the shortest path block: function codes, default sizes, widths and result kind codes
// no dependencies
`default_nettype none
package spbv_pkg;
    localparam int unsigned DEF_MAX_VERTICES = 64;
    localparam int unsigned DEF_DIST_BITS    = 24;
    localparam int unsigned VTX_W            = 6;
    localparam int unsigned FUNC_W           = 3;
    localparam int unsigned COST_W           = 16;
    localparam int unsigned OUT_DIST_W       = 24;
    localparam int unsigned COUNT_W          = 7;

    localparam logic [FUNC_W-1:0] FN_ADD   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_BLOCK = 3'd1;
    localparam logic [FUNC_W-1:0] FN_RUN   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_READ  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd4;

    localparam logic RK_RUN  = 1'b0;
    localparam logic RK_READ = 1'b1;
endpackage
`default_nettype wire

// ===== sv/spbv_mem.sv =====
// cost matrix memory: one write port, one registered read port
// uses spbv_pkg for the cost width
`default_nettype none
module spbv_mem #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = 12
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [AW-1:0]             i_waddr,
    input  wire logic [spbv_pkg::COST_W:0] i_wdata,
    input  wire logic [AW-1:0]             i_raddr,
    output logic      [spbv_pkg::COST_W:0] o_rdata
);
    import spbv_pkg::*;
    logic [COST_W:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/shortest_path_with_blocked_vertices.sv =====
// Iterative single-source shortest path engine over a cost matrix held in one RAM. busy stays
// high while an item is worked on; results appear for one cycle on o_valid and the receiver
// cannot stall them. An add edge reads and conditionally writes both matrix halves through the
// RAM's read and write ports; a block is taken in idle and busy does not rise; a read passes
// through the read state; a clear is a sweep that writes one matrix entry a cycle; a run
// repeats, per settled vertex, a scan for the minimum over all vertices, a pick and a row pass
// through the shared add/compare unit; the last scan finds nothing and is followed by a pick,
// a count pass and a done state. A read or run result is on the outputs in the cycle in which
// busy falls. After reset the same clearing sweep runs before the first item is taken.
// uses spbv_pkg and spbv_mem
`default_nettype none
module shortest_path_with_blocked_vertices #(
    parameter int unsigned MAX_VERTICES = spbv_pkg::DEF_MAX_VERTICES,
    parameter int unsigned DIST_BITS    = spbv_pkg::DEF_DIST_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [spbv_pkg::FUNC_W-1:0]     i_func,
    input  wire logic [spbv_pkg::VTX_W-1:0]      i_vertex_a,
    input  wire logic [spbv_pkg::VTX_W-1:0]      i_vertex_b,
    input  wire logic [spbv_pkg::COST_W-1:0]     i_edge_cost,
    output logic                                 o_valid,
    output logic                                 o_result_kind,
    output logic [spbv_pkg::OUT_DIST_W-1:0]      o_distance,
    output logic                                 o_unreachable,
    output logic [spbv_pkg::COUNT_W-1:0]         o_reached_count
);
    import spbv_pkg::*;

    localparam int unsigned VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int unsigned CW    = $clog2(MAX_VERTICES + 1);
    localparam int unsigned AW    = 2 * VW;
    localparam int unsigned DEPTH = 2 ** AW;
    localparam logic [DIST_BITS-1:0] DMAX = '1;
    localparam logic [VTX_W:0] NV = (VTX_W+1)'(MAX_VERTICES > 64 ? 64 : MAX_VERTICES);

    typedef enum logic [11:0] {
        S_CLR   = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_ERD1  = 12'b000000000100,
        S_EWR1  = 12'b000000001000,
        S_ERD2  = 12'b000000010000,
        S_EWR2  = 12'b000000100000,
        S_SCAN  = 12'b000001000000,
        S_PICK  = 12'b000010000000,
        S_RELAX = 12'b000100000000,
        S_COUNT = 12'b001000000000,
        S_DONE  = 12'b010000000000,
        S_READ  = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic [AW:0]      r_idx, n_idx;
    logic [VW-1:0]    r_ea, n_ea, r_eb, n_eb;
    logic [COST_W-1:0] r_cost, n_cost;
    logic [VW:0]      r_best, n_best;
    logic [DIST_BITS-1:0] r_bdist, n_bdist;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [MAX_VERTICES-1:0] r_blk, n_blk, r_reach, n_reach, r_set, n_set;
    logic [DIST_BITS-1:0] r_dist [MAX_VERTICES];
    logic [DIST_BITS-1:0] r_drd;
    logic              dist_we;
    logic [VW-1:0]     dist_wa, dist_ra;
    logic [DIST_BITS-1:0] dist_wd;

    logic              mem_we;
    logic [AW-1:0]     mem_wa, mem_ra;
    logic [COST_W:0]   mem_wd, mem_rd;

    logic              r_valid, n_valid;
    logic              r_kind, n_kind, r_unr, n_unr;
    logic [OUT_DIST_W-1:0] r_odist, n_odist;

    logic [VW-1:0]     in_a, in_b;
    assign in_a = VW'(i_vertex_a);
    assign in_b = VW'(i_vertex_b);

    spbv_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_wa),
        .i_wdata (mem_wd),
        .i_raddr (mem_ra),
        .o_rdata (mem_rd)
    );

    // shared unit: add with saturation and compare
    logic [VW-1:0]      sh_i;
    logic [DIST_BITS:0] sum;
    logic [DIST_BITS-1:0] nd;
    logic [VW-1:0]      best_v, pv;
    assign best_v = r_best[VW-1:0];
    assign sum    = {1'b0, r_bdist} + (DIST_BITS+1)'(mem_rd[COST_W-1:0]);
    assign nd     = sum[DIST_BITS] ? DMAX : sum[DIST_BITS-1:0];
    assign sh_i   = r_idx[VW-1:0];
    // matrix and distance reads are registered, so their data belongs to the index of the previous cycle, pv
    assign pv     = VW'(r_idx - 1'b1);

    always_comb begin
        n_state = r_state; n_idx = r_idx; n_ea = r_ea; n_eb = r_eb; n_cost = r_cost;
        n_best = r_best; n_bdist = r_bdist; n_cnt = r_cnt;
        n_blk = r_blk; n_reach = r_reach; n_set = r_set;
        n_valid = 1'b0; n_kind = r_kind; n_unr = r_unr; n_odist = r_odist;
        dist_we = 1'b0; dist_wa = '0; dist_wd = '0; dist_ra = '0;
        mem_we = 1'b0; mem_wa = '0; mem_wd = {1'b1, {COST_W{1'b0}}}; mem_ra = '0;
        case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
                mem_wa = r_idx[AW-1:0];
                n_idx = r_idx + 1'b1;
                if (r_idx == (AW+1)'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                dist_ra = in_a;
                if (start) begin
                    n_ea = in_a;
                    n_eb = in_b;
                    n_cost = i_edge_cost;
                    case (i_func)
                        FN_ADD: begin
                            if ({1'b0, i_vertex_a} < NV && {1'b0, i_vertex_b} < NV) begin
                                n_state = S_ERD1;
                            end
                        end
                        FN_BLOCK: begin
                            if ({1'b0, i_vertex_a} < NV) begin
                                n_blk[in_a] = 1'b1;
                            end
                        end
                        FN_RUN: begin
                            n_reach = '0; n_set = '0; n_cnt = '0;
                            n_idx = '0;
                            n_best = {1'b1, {VW{1'b0}}};
                            if ({1'b0, i_vertex_a} < NV) begin
                                n_reach[in_a] = 1'b1;
                                dist_we = 1'b1;
                                dist_wa = in_a;
                                n_state = S_SCAN;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        FN_READ: begin
                            n_unr = !({1'b0, i_vertex_a} < NV && r_reach[in_a]);
                            n_state = S_READ;
                        end
                        FN_CLEAR: begin
                            n_blk = '0; n_reach = '0; n_set = '0; n_cnt = '0;
                            n_idx = '0;
                            n_state = S_CLR;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                n_valid = 1'b1;
                n_kind = RK_READ;
                n_odist = r_unr ? '0 : OUT_DIST_W'(r_drd);
                n_state = S_IDLE;
            end
            S_ERD1: begin
                mem_ra = {r_ea, r_eb};
                n_state = S_EWR1;
            end
            S_EWR1: begin
                if (mem_rd[COST_W] || r_cost < mem_rd[COST_W-1:0]) begin
                    mem_we = 1'b1;
                    mem_wa = {r_ea, r_eb};
                    mem_wd = {1'b0, r_cost};
                end
                n_state = S_ERD2;
            end
            S_ERD2: begin
                mem_ra = {r_eb, r_ea};
                n_state = S_EWR2;
            end
            S_EWR2: begin
                if (mem_rd[COST_W] || r_cost < mem_rd[COST_W-1:0]) begin
                    mem_we = 1'b1;
                    mem_wa = {r_eb, r_ea};
                    mem_wd = {1'b0, r_cost};
                end
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (r_idx < (AW+1)'(MAX_VERTICES)) begin
                    dist_ra = sh_i;
                end
                // one candidate per cycle against the running minimum
                if (r_idx != '0) begin
                    if (r_reach[pv] && !r_set[pv] && (r_best[VW] || r_drd < r_bdist)) begin
                        n_best = {1'b0, pv};
                        n_bdist = r_drd;
                    end
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == (AW+1)'(MAX_VERTICES)) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                n_idx = '0;
                if (r_best[VW]) begin
                    n_state = S_COUNT;
                end else begin
                    n_set[best_v] = 1'b1;
                    n_state = S_RELAX;
                end
            end
            S_RELAX: begin
                if (r_idx < (AW+1)'(MAX_VERTICES)) begin
                    mem_ra = {best_v, sh_i};
                    dist_ra = sh_i;
                end
                if (r_idx != '0) begin
                    if (!mem_rd[COST_W] && !r_blk[pv] && !r_set[pv] &&
                        (!r_reach[pv] || nd < r_drd)) begin
                        dist_we = 1'b1;
                        dist_wa = pv;
                        dist_wd = nd;
                        n_reach[pv] = 1'b1;
                    end
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == (AW+1)'(MAX_VERTICES)) begin
                    n_idx = '0;
                    n_best = {1'b1, {VW{1'b0}}};
                    n_state = S_SCAN;
                end
            end
            S_COUNT: begin
                n_cnt = r_cnt + CW'(r_reach[sh_i]);
                n_idx = r_idx + 1'b1;
                if (r_idx == (AW+1)'(MAX_VERTICES - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_valid = 1'b1;
                n_kind = RK_RUN;
                n_odist = '0;
                n_unr = 1'b0;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_idx <= '0;
            r_blk <= '0; r_reach <= '0; r_set <= '0; r_cnt <= '0;
            r_valid <= 1'b0;
            r_best <= '0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
            r_blk <= n_blk; r_reach <= n_reach; r_set <= n_set; r_cnt <= n_cnt;
            r_valid <= n_valid;
            r_best <= n_best;
        end
        r_ea <= n_ea; r_eb <= n_eb; r_cost <= n_cost; r_bdist <= n_bdist;
        r_kind <= n_kind; r_unr <= n_unr; r_odist <= n_odist;
        if (dist_we) begin
            r_dist[dist_wa] <= dist_wd;
        end
        r_drd <= r_dist[dist_ra];
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_result_kind   = r_kind;
    assign o_distance      = r_odist;
    assign o_unreachable   = r_unr;
    assign o_reached_count = COUNT_W'(r_cnt);

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_state == S_IDLE) else $error("result outside idle");
    a_settled_reached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_set & ~r_reach) == '0) else $error("settled vertex not reached");
    a_pick_settles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK && !r_best[VW]) |=> r_set[$past(best_v)])
        else $error("picked vertex not settled");
    a_run_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind == RK_RUN) |-> (r_odist == '0 && !r_unr))
        else $error("run result fields wrong");
endmodule
`default_nettype wire

// ===== tb/tb_shortest_path_with_blocked_vertices.sv =====
// testbench for shortest_path_with_blocked_vertices: directed table then random graph items
// checks each result against an in-bench shortest path predictor or a typed answer; depends on spbv_pkg
`default_nettype none
module tb_shortest_path_with_blocked_vertices;
    import spbv_pkg::*;

    localparam int NV       = 64;
    localparam logic [16:0] NO_LINK = 17'h10000;
    localparam logic [23:0] DMAX    = 24'hFFFFFF;
    localparam int WDOG_LIMIT = 200000;

    typedef struct packed {
        logic        kind;
        logic [23:0] plen;
        logic        unreach;
        logic [6:0]  count;
    } answer_t;

    typedef struct {
        logic [2:0]  fn;
        logic [5:0]  va;
        logic [5:0]  vb;
        logic [15:0] cost;
        bit          typed;
        answer_t     ans;
    } row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [2:0] i_func = '0;
    logic [5:0] i_vertex_a = '0, i_vertex_b = '0;
    logic [15:0] i_edge_cost = '0;
    logic o_valid, o_result_kind, o_unreachable;
    logic [23:0] o_distance;
    logic [6:0] o_reached_count;

    always #2 i_clk = ~i_clk;

    shortest_path_with_blocked_vertices dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_vertex_a(i_vertex_a), .i_vertex_b(i_vertex_b),
        .i_edge_cost(i_edge_cost), .o_valid(o_valid), .o_result_kind(o_result_kind),
        .o_distance(o_distance), .o_unreachable(o_unreachable),
        .o_reached_count(o_reached_count)
    );

    // predictor state
    logic [16:0] link_cost [NV*NV];
    bit          blocked [NV];
    logic [23:0] path_len [NV];
    bit          reached [NV];
    bit          settled [NV];
    logic [6:0]  reach_total;

    answer_t pending_answers [$];
    int mismatches = 0, results_seen = 0, items_sent = 0, runs_sent = 0;
    int idle_cycles = 0;

    function automatic void wipe_graph();
        for (int i = 0; i < NV*NV; i++) link_cost[i] = NO_LINK;
        for (int i = 0; i < NV; i++) begin
            blocked[i] = 0; path_len[i] = '0; reached[i] = 0; settled[i] = 0;
        end
        reach_total = '0;
    endfunction

    function automatic void relax_from(int src);
        int best;
        logic [16:0] c;
        logic [24:0] nd;
        for (int i = 0; i < NV; i++) begin
            path_len[i] = '0; reached[i] = 0; settled[i] = 0;
        end
        reach_total = '0;
        reached[src] = 1;
        forever begin
            best = NV;
            for (int i = 0; i < NV; i++)
                if (reached[i] && !settled[i] && (best == NV || path_len[i] < path_len[best]))
                    best = i;
            if (best == NV) break;
            settled[best] = 1;
            for (int v = 0; v < NV; v++) begin
                c = link_cost[best*NV+v];
                if (c[16] || blocked[v] || settled[v]) continue;
                nd = {1'b0, path_len[best]} + {9'b0, c[15:0]};
                if (nd > {1'b0, DMAX}) nd = {1'b0, DMAX};
                if (!reached[v] || nd[23:0] < path_len[v]) begin
                    path_len[v] = nd[23:0]; reached[v] = 1;
                end
            end
        end
        for (int i = 0; i < NV; i++) reach_total += reached[i];
    endfunction

    // returns 1 when the item produces an answer
    function automatic bit predict_item(logic [2:0] fn, logic [5:0] a, logic [5:0] b,
                                        logic [15:0] cost, output answer_t ans);
        ans = '0;
        case (fn)
            FN_ADD: begin
                if (link_cost[a*NV+b][16] || cost < link_cost[a*NV+b]) link_cost[a*NV+b] = cost;
                if (link_cost[b*NV+a][16] || cost < link_cost[b*NV+a]) link_cost[b*NV+a] = cost;
                return 0;
            end
            FN_BLOCK: begin blocked[a] = 1; return 0; end
            FN_RUN: begin
                relax_from(a);
                ans.kind = RK_RUN; ans.count = reach_total;
                return 1;
            end
            FN_READ: begin
                ans.kind = RK_READ;
                ans.plen = reached[a] ? path_len[a] : '0;
                ans.unreach = !reached[a];
                ans.count = reach_total;
                return 1;
            end
            FN_CLEAR: begin wipe_graph(); return 0; end
            default: return 0;
        endcase
    endfunction

    // start stays high from one item to the next unless a gap is taken
    task automatic issue(logic [2:0] fn, logic [5:0] a, logic [5:0] b, logic [15:0] cost,
                         bit typed, answer_t typed_ans, bit allow_gap);
        answer_t ans;
        if (allow_gap && $urandom_range(99) < 23) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 23);
        end
        start <= 1'b1; i_func <= fn; i_vertex_a <= a; i_vertex_b <= b; i_edge_cost <= cost;
        // busy is stable at the falling edge, so the next rising edge accepts when it is low
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        items_sent++;
        if (fn == FN_RUN) runs_sent++;
        if (predict_item(fn, a, b, cost, ans)) begin
            if (typed && ans != typed_ans)
                $display("directed row disagrees with predictor fn=%0d a=%0d", fn, a);
            pending_answers.push_back(typed ? typed_ans : ans);
        end
    endtask

    // result checking
    always @(posedge i_clk) begin
        answer_t got, want;
        if (i_rst_n && o_valid) begin
            got = '{o_result_kind, o_distance, o_unreachable, o_reached_count};
            results_seen++;
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = pending_answers.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch expected %p actual %p", want, got);
                end
            end
        end
    end

    // watchdog: cycles with nothing accepted and no result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog expired");
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic answer_t mk(logic k, logic [23:0] d, logic u, logic [6:0] c);
        return '{k, d, u, c};
    endfunction

    row_t table_rows [$];

    initial begin
        logic [2:0] fn;
        logic [5:0] a, b;
        int n_vtx, roll;
        wipe_graph();
        // directed rows; answers typed in where obvious
        table_rows = '{
            '{FN_READ, 6'd63, 6'd0, 16'd0, 1, mk(RK_READ, 0, 1, 0)},
            '{FN_RUN, 6'd5, 6'd0, 16'd0, 1, mk(RK_RUN, 0, 0, 1)},
            '{FN_READ, 6'd5, 6'd0, 16'd0, 1, mk(RK_READ, 0, 0, 1)},
            '{FN_ADD, 6'd0, 6'd63, 16'hFFFF, 0, '0},
            '{FN_ADD, 6'd63, 6'd62, 16'hFFFF, 0, '0},
            '{FN_ADD, 6'd62, 6'd61, 16'hFFFF, 0, '0},
            '{FN_ADD, 6'd0, 6'd63, 16'hFFFF, 0, '0},
            '{FN_ADD, 6'd0, 6'd1, 16'd0, 0, '0},
            '{FN_ADD, 6'd1, 6'd1, 16'd7, 0, '0},
            '{FN_ADD, 6'd1, 6'd2, 16'd10, 0, '0},
            '{FN_ADD, 6'd2, 6'd1, 16'd3, 0, '0},
            '{FN_ADD, 6'd2, 6'd3, 16'd1, 0, '0},
            '{FN_BLOCK, 6'd3, 6'd0, 16'd0, 0, '0},
            '{FN_BLOCK, 6'd0, 6'd0, 16'd0, 0, '0},
            '{3'd5, 6'd1, 6'd2, 16'd1, 0, '0},
            '{3'd7, 6'd63, 6'd63, 16'hFFFF, 0, '0},
            '{FN_RUN, 6'd0, 6'd0, 16'd0, 0, '0},
            '{FN_READ, 6'd61, 6'd0, 16'd0, 0, '0},
            '{FN_READ, 6'd2, 6'd0, 16'd0, 0, '0},
            '{FN_READ, 6'd3, 6'd0, 16'd0, 0, '0},
            '{FN_RUN, 6'd3, 6'd0, 16'd0, 0, '0},
            '{FN_READ, 6'd0, 6'd0, 16'd0, 0, '0},
            '{FN_CLEAR, 6'd0, 6'd0, 16'd0, 0, '0},
            '{FN_READ, 6'd2, 6'd0, 16'd0, 1, mk(RK_READ, 0, 1, 0)}
        };
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (table_rows[i])
            issue(table_rows[i].fn, table_rows[i].va, table_rows[i].vb, table_rows[i].cost,
                  table_rows[i].typed, table_rows[i].ans, 0);

        // random graphs: mostly small vertex sets with edges, a few blocks, then run and reads
        for (int g = 0; items_sent < 130; g++) begin
            n_vtx = ($urandom_range(7) == 0) ? 64 : $urandom_range(4, 12);
            for (int k = 0; k < $urandom_range(4, 10); k++) begin
                roll = $urandom_range(99);
                a = 6'($urandom_range(n_vtx-1)); b = 6'($urandom_range(n_vtx-1));
                if (roll < 75) fn = FN_ADD;
                else if (roll < 87) fn = FN_BLOCK;
                else if (roll < 92) fn = 3'($urandom_range(5, 7));
                else fn = FN_READ;
                if (n_vtx == 64) begin a = 6'($urandom); b = 6'($urandom); end
                issue(fn, a, b, ($urandom_range(3) == 0) ? 16'($urandom_range(65000, 65535))
                                                         : 16'($urandom), 0, '0, g >= 3);
            end
            issue(FN_RUN, 6'($urandom_range(n_vtx-1)), 6'($urandom), 16'($urandom), 0, '0, g >= 3);
            for (int k = 0; k < 3; k++)
                issue(FN_READ, 6'($urandom_range(n_vtx-1)), 6'($urandom), 16'($urandom),
                      0, '0, g >= 3);
            if ($urandom_range(2) == 0)
                issue(FN_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom), 0, '0, g >= 3);
        end
        start <= 1'b0;

        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (20000) @(posedge i_clk);
        $display("sent %0d items including %0d path runs, checked %0d results",
                 items_sent, runs_sent, results_seen);
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
sv/spbv_pkg.sv
sv/spbv_mem.sv
sv/shortest_path_with_blocked_vertices.sv
tb/tb_shortest_path_with_blocked_vertices.sv
